[src/are_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive range encoder package
// Shared constants, register codes, controller states, datapath commands and
// the status bundle that runs between the controller and the datapath.
// ----------------------------------------------------------------------------
package are_pkg;

  // Default sizes handed to the top level parameters.
  localparam int MAX_SYMBOL_BITS_DEF = 8;
  localparam int COUNT_BITS_DEF      = 21;

  // Register reset values.
  localparam logic [4:0] INPUT_BITS_RST  = 5'd8;
  localparam logic [3:0] SYMBOL_BITS_RST = 4'd8;

  // Register index, taken from address bit 2.
  typedef enum logic {
    REG_INPUT_BITS  = 1'b0,
    REG_SYMBOL_BITS = 1'b1
  } reg_idx_t;

  // Controller states.
  typedef enum logic [4:0] {
    S_INIT_START,
    S_INIT,
    S_IDLE,
    S_CUM_RD,
    S_CUM_ACC,
    S_FREQ_RD,
    S_FREQ_LD,
    S_DIV,
    S_MUL_CLO,
    S_MUL_CHI,
    S_SUM_PROD,
    S_ADD_LOW,
    S_MUL_RLO,
    S_MUL_RHI,
    S_SET_RANGE,
    S_BUMP_CHK,
    S_BUMP_RD,
    S_BUMP_WR,
    S_RENORM,
    S_FLUSH
  } state_t;

  // Datapath commands, one per cycle.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_INIT_START,
    OP_INIT_STEP,
    OP_LOAD,
    OP_CUM_RD,
    OP_CUM_ACC,
    OP_FREQ_RD,
    OP_FREQ_LD,
    OP_DIV_STEP,
    OP_MUL_CLO,
    OP_MUL_CHI,
    OP_SUM_PROD,
    OP_ADD_LOW,
    OP_MUL_RLO,
    OP_MUL_RHI,
    OP_SET_RANGE,
    OP_BUMP_CHK,
    OP_BUMP_RD,
    OP_BUMP_WR,
    OP_RENORM,
    OP_FLUSH
  } dp_op_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic init_last;
    logic lvl_last;
    logic div_last;
    logic count_full;
    logic renorm_need;
    logic fill_full;
    logic out_free;
    logic flush_last;
    logic item_last;
  } dp_status_t;

endpackage

[src/are_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive range encoder controller
// Sequences one sample through tree walk, division, multiplies, count update,
// renormalization or flush, and the model initialization sweep.
// ----------------------------------------------------------------------------
module are_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr,
  input  logic              in_valid,
  output logic              in_stall,
  input  are_pkg::dp_status_t status,
  output are_pkg::dp_op_t   op
);

  are_pkg::state_t state;
  are_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= are_pkg::S_INIT_START;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command.
  always_comb begin
    state_next = state;
    op         = are_pkg::OP_NOP;
    in_stall   = 1'b1;
    case (state)
      are_pkg::S_INIT_START: begin
        op         = are_pkg::OP_INIT_START;
        state_next = are_pkg::S_INIT;
      end
      are_pkg::S_INIT: begin
        op = are_pkg::OP_INIT_STEP;
        if (status.init_last) begin
          state_next = are_pkg::S_IDLE;
        end
      end
      are_pkg::S_IDLE: begin
        in_stall = cfg_wr;
        if (in_valid && !cfg_wr) begin
          op         = are_pkg::OP_LOAD;
          state_next = are_pkg::S_CUM_RD;
        end
      end
      are_pkg::S_CUM_RD: begin
        op         = are_pkg::OP_CUM_RD;
        state_next = are_pkg::S_CUM_ACC;
      end
      are_pkg::S_CUM_ACC: begin
        op         = are_pkg::OP_CUM_ACC;
        state_next = status.lvl_last ? are_pkg::S_FREQ_RD : are_pkg::S_CUM_RD;
      end
      are_pkg::S_FREQ_RD: begin
        op         = are_pkg::OP_FREQ_RD;
        state_next = are_pkg::S_FREQ_LD;
      end
      are_pkg::S_FREQ_LD: begin
        op         = are_pkg::OP_FREQ_LD;
        state_next = are_pkg::S_DIV;
      end
      are_pkg::S_DIV: begin
        op = are_pkg::OP_DIV_STEP;
        if (status.div_last) begin
          state_next = are_pkg::S_MUL_CLO;
        end
      end
      are_pkg::S_MUL_CLO: begin
        op         = are_pkg::OP_MUL_CLO;
        state_next = are_pkg::S_MUL_CHI;
      end
      are_pkg::S_MUL_CHI: begin
        op         = are_pkg::OP_MUL_CHI;
        state_next = are_pkg::S_SUM_PROD;
      end
      are_pkg::S_SUM_PROD: begin
        op         = are_pkg::OP_SUM_PROD;
        state_next = are_pkg::S_ADD_LOW;
      end
      are_pkg::S_ADD_LOW: begin
        op         = are_pkg::OP_ADD_LOW;
        state_next = are_pkg::S_MUL_RLO;
      end
      are_pkg::S_MUL_RLO: begin
        op         = are_pkg::OP_MUL_RLO;
        state_next = are_pkg::S_MUL_RHI;
      end
      are_pkg::S_MUL_RHI: begin
        op         = are_pkg::OP_MUL_RHI;
        state_next = are_pkg::S_SET_RANGE;
      end
      are_pkg::S_SET_RANGE: begin
        op         = are_pkg::OP_SET_RANGE;
        state_next = are_pkg::S_BUMP_CHK;
      end
      are_pkg::S_BUMP_CHK: begin
        op = are_pkg::OP_BUMP_CHK;
        if (!status.count_full) begin
          state_next = are_pkg::S_BUMP_RD;
        end else begin
          state_next = status.item_last ? are_pkg::S_FLUSH : are_pkg::S_RENORM;
        end
      end
      are_pkg::S_BUMP_RD: begin
        op         = are_pkg::OP_BUMP_RD;
        state_next = are_pkg::S_BUMP_WR;
      end
      are_pkg::S_BUMP_WR: begin
        op = are_pkg::OP_BUMP_WR;
        if (!status.lvl_last) begin
          state_next = are_pkg::S_BUMP_RD;
        end else begin
          state_next = status.item_last ? are_pkg::S_FLUSH : are_pkg::S_RENORM;
        end
      end
      are_pkg::S_RENORM: begin
        if (!status.renorm_need) begin
          state_next = are_pkg::S_IDLE;
        end else if (!status.fill_full || status.out_free) begin
          op = are_pkg::OP_RENORM;
        end
      end
      are_pkg::S_FLUSH: begin
        if (status.out_free) begin
          op = are_pkg::OP_FLUSH;
          if (status.flush_last) begin
            state_next = are_pkg::S_INIT_START;
          end
        end
      end
      default: begin
        state_next = are_pkg::S_INIT_START;
      end
    endcase
    // A register write restarts the message.
    if (cfg_wr) begin
      state_next = are_pkg::S_INIT_START;
    end
  end

endmodule

[src/are_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive range encoder datapath
// Quantizer, count tree memory, serial divider, shared 32-bit multiplier,
// coder registers and the output word register.
// ----------------------------------------------------------------------------
module are_dp #(
  parameter int MAX_SYMBOL_BITS = are_pkg::MAX_SYMBOL_BITS_DEF,
  parameter int COUNT_BITS      = are_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  are_pkg::dp_op_t     op,
  output are_pkg::dp_status_t status,
  input  logic [4:0]          input_bits,
  input  logic [3:0]          symbol_bits,
  input  logic signed [15:0]  sample,
  input  logic                is_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_word,
  output logic                final_word,
  output logic                count_overflow
);

  localparam int AW    = MAX_SYMBOL_BITS + 1;
  localparam int DEPTH = 2 ** AW;
  localparam int LW    = $clog2(MAX_SYMBOL_BITS + 1);
  localparam int PW    = 32 + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Count tree memory.
  logic [COUNT_BITS-1:0] tree_mem [DEPTH];
  logic [COUNT_BITS-1:0] rd_data;
  logic [AW-1:0]         mem_addr;
  logic                  mem_rd;
  logic                  mem_wr;
  logic [COUNT_BITS-1:0] wr_data;

  // Model and coder state.
  logic [COUNT_BITS-1:0]      total;
  logic [COUNT_BITS-1:0]      cum;
  logic [COUNT_BITS-1:0]      freq;
  logic [63:0]                range;
  logic [63:0]                low;
  logic [63:0]                pending;
  logic [2:0]                 fill;
  logic                       overflow_seen;
  logic                       carry;
  logic [COUNT_BITS:0]        rem;
  logic [5:0]                 dcnt;
  logic [PW-1:0]              prod_lo;
  logic [PW-1:0]              prod_hi;
  logic [63:0]                prod_sum;
  logic [MAX_SYMBOL_BITS-1:0] sym;
  logic                       last;
  logic [LW-1:0]              lvl;
  logic [LW-1:0]              ilvl;
  logic [AW-1:0]              ij;
  logic [2:0]                 fidx;

  // Effective symbol width and alphabet size.
  logic [LW-1:0] qb;
  logic [AW-1:0] num;
  always_comb begin
    if (symbol_bits == 4'd0) begin
      qb = LW'(1);
    end else if (int'(symbol_bits) > MAX_SYMBOL_BITS) begin
      qb = LW'(MAX_SYMBOL_BITS);
    end else begin
      qb = LW'(symbol_bits);
    end
    num = AW'(1) << qb;
  end

  // Address of an entry at a tree level.
  function automatic logic [AW-1:0] node_addr(input logic [LW-1:0] q,
                                               input logic [LW-1:0] l,
                                               input logic [AW-1:0] node);
    logic [AW:0] full;
    logic [AW:0] part;
    logic [AW:0] sum;
    full = (AW+1)'(2) << q;
    part = (AW+1)'(2) << (q - l);
    sum  = full - part + {1'b0, node};
    return sum[AW-1:0];
  endfunction

  // Dead-zone quantizer.
  logic [16:0]        mag;
  logic [4:0]         del;
  logic [31:0]        sub;
  logic signed [32:0] dif;
  logic [31:0]        mq;
  logic signed [19:0] qs;
  logic signed [19:0] numv;
  logic [MAX_SYMBOL_BITS-1:0] sym_q;
  always_comb begin
    mag  = sample[15] ? (17'd0 - {sample[15], sample}) : {1'b0, sample};
    del  = (int'(input_bits) > int'(qb)) ? (input_bits - 5'(qb)) : 5'd0;
    sub  = (32'd1 << del) >> 1;
    dif  = $signed({16'd0, mag}) - $signed({1'b0, sub});
    mq   = dif[32] ? 32'd0 : (dif[31:0] >> del);
    qs   = $signed({3'b000, mq[16:0]});
    if (sample[15]) begin
      qs = -qs;
    end
    numv = $signed(20'(num));
    qs   = qs + (numv >>> 1);
    if (qs < 0) begin
      qs = '0;
    end else if (qs > numv - 20'sd1) begin
      qs = numv - 20'sd1;
    end
    sym_q = qs[MAX_SYMBOL_BITS-1:0];
  end

  // Tree walk helpers.
  logic [AW-1:0] node;
  logic          lvl_last;
  logic [AW-1:0] init_lastj;
  logic          init_last;
  always_comb begin
    node       = AW'(sym) >> lvl;
    lvl_last   = (lvl == qb - LW'(1));
    init_lastj = (num >> ilvl) - AW'(1);
    init_last  = (ilvl == qb - LW'(1)) && (ij == init_lastj);
  end

  // Memory port control.
  always_comb begin
    mem_addr = node_addr(qb, lvl, node);
    mem_rd   = 1'b0;
    mem_wr   = 1'b0;
    wr_data  = rd_data + COUNT_BITS'(1);
    case (op)
      are_pkg::OP_INIT_STEP: begin
        mem_addr = node_addr(qb, ilvl, ij);
        mem_wr   = 1'b1;
        wr_data  = COUNT_BITS'(1) << ilvl;
      end
      are_pkg::OP_CUM_RD: begin
        mem_addr = node_addr(qb, lvl, node - AW'(1));
        mem_rd   = 1'b1;
      end
      are_pkg::OP_FREQ_RD: begin
        mem_addr = AW'(sym);
        mem_rd   = 1'b1;
      end
      are_pkg::OP_BUMP_RD: begin
        mem_rd = 1'b1;
      end
      are_pkg::OP_BUMP_WR: begin
        mem_wr = 1'b1;
      end
      default: begin
        mem_rd = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      tree_mem[mem_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rd_data <= tree_mem[mem_addr];
    end
  end

  // Shared multiplier: one half of range by cum or freq.
  logic [31:0]           mul_a;
  logic [COUNT_BITS-1:0] mul_b;
  logic [PW-1:0]         mul_p;
  always_comb begin
    mul_a = ((op == are_pkg::OP_MUL_CHI) || (op == are_pkg::OP_MUL_RHI)) ?
            range[63:32] : range[31:0];
    mul_b = ((op == are_pkg::OP_MUL_RLO) || (op == are_pkg::OP_MUL_RHI)) ? freq : cum;
    mul_p = PW'(mul_a) * PW'(mul_b);
  end

  // Divider step.
  logic [COUNT_BITS:0] rem_sh;
  logic                qbit;
  logic [COUNT_BITS:0] rem_nx;
  always_comb begin
    rem_sh = {rem[COUNT_BITS-1:0], range[63]};
    qbit   = (rem_sh >= {1'b0, total});
    rem_nx = qbit ? (rem_sh - {1'b0, total}) : rem_sh;
  end

  logic [63:0] prod_wide;
  logic [64:0] low_sum;
  logic        out_free;
  logic        load_out;
  always_comb begin
    prod_wide = 64'(prod_lo) + {prod_hi[31:0], 32'd0};
    low_sum   = {1'b0, low} + {1'b0, prod_sum};
    out_free  = !out_valid || !out_stall;
    load_out  = ((op == are_pkg::OP_RENORM) && (fill >= 3'd4)) ||
                (op == are_pkg::OP_FLUSH);
  end

  // Coder and model registers.
  always_ff @(posedge clk) begin
    case (op)
      are_pkg::OP_INIT_START: begin
        total   <= COUNT_BITS'(num);
        range   <= '1;
        low     <= '0;
        pending <= '0;
        ilvl    <= '0;
        ij      <= '0;
      end
      are_pkg::OP_INIT_STEP: begin
        if (ij == init_lastj) begin
          ilvl <= ilvl + LW'(1);
          ij   <= '0;
        end else begin
          ij <= ij + AW'(1);
        end
      end
      are_pkg::OP_LOAD: begin
        sym  <= sym_q;
        last <= is_last;
        cum  <= '0;
        lvl  <= '0;
        fidx <= '0;
      end
      are_pkg::OP_CUM_ACC: begin
        if (node[0]) begin
          cum <= cum + rd_data;
        end
        lvl <= lvl + LW'(1);
      end
      are_pkg::OP_FREQ_LD: begin
        freq <= rd_data;
        rem  <= '0;
        dcnt <= '0;
      end
      are_pkg::OP_DIV_STEP: begin
        rem   <= rem_nx;
        range <= {range[62:0], qbit};
        dcnt  <= dcnt + 6'd1;
      end
      are_pkg::OP_MUL_CLO, are_pkg::OP_MUL_RLO: begin
        prod_lo <= mul_p;
      end
      are_pkg::OP_MUL_CHI, are_pkg::OP_MUL_RHI: begin
        prod_hi <= mul_p;
      end
      are_pkg::OP_SUM_PROD: begin
        prod_sum <= prod_wide;
      end
      are_pkg::OP_ADD_LOW: begin
        low   <= low_sum[63:0];
        carry <= low_sum[64];
      end
      are_pkg::OP_SET_RANGE: begin
        range   <= prod_wide;
        pending <= pending + 64'(carry);
      end
      are_pkg::OP_BUMP_CHK: begin
        lvl <= '0;
      end
      are_pkg::OP_BUMP_WR: begin
        lvl <= lvl + LW'(1);
        if (lvl_last) begin
          total <= total + COUNT_BITS'(1);
        end
      end
      are_pkg::OP_RENORM: begin
        pending <= {pending[47:0], low[63:48]};
        low     <= {low[47:0], 16'd0};
        range   <= {range[47:0], 16'd0};
      end
      are_pkg::OP_FLUSH: begin
        pending <= {pending[47:0], low[63:48]};
        low     <= {low[47:0], 16'd0};
        fidx    <= fidx + 3'd1;
      end
      default: begin
        carry <= carry;
      end
    endcase
  end

  // Fill count and overflow flag.
  always_ff @(posedge clk) begin
    if (rst || (op == are_pkg::OP_INIT_START)) begin
      fill          <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if ((op == are_pkg::OP_RENORM) && (fill < 3'd4)) begin
        fill <= fill + 3'd1;
      end
      if ((op == are_pkg::OP_BUMP_CHK) && (total == COUNT_MAX)) begin
        overflow_seen <= 1'b1;
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word       <= pending[63:48];
      final_word     <= (op == are_pkg::OP_FLUSH) && (fidx == 3'd7);
      count_overflow <= overflow_seen;
    end
  end

  // Status to the controller.
  always_comb begin
    status.init_last   = init_last;
    status.lvl_last    = lvl_last;
    status.div_last    = (dcnt == 6'd63);
    status.count_full  = (total == COUNT_MAX);
    status.renorm_need = (range != 64'd0) && (range[63:48] == 16'd0);
    status.fill_full   = (fill >= 3'd4);
    status.out_free    = out_free;
    status.flush_last  = (fidx == 3'd7);
    status.item_last   = last;
  end

  // Checks.
  default disable iff (rst);

  a_fill_bound: assert property (@(posedge clk) fill <= 3'd4)
    else $error("pending fill count past four words");

  a_rem_below: assert property (@(posedge clk)
    $past(op == are_pkg::OP_DIV_STEP) |-> (rem < {1'b0, total}))
    else $error("divider remainder not below the total count");

  a_load_free: assert property (@(posedge clk) load_out |-> out_free)
    else $error("output word loaded over a word still held");

  a_total_nz: assert property (@(posedge clk)
    (op == are_pkg::OP_DIV_STEP) |-> (total != '0))
    else $error("division by a zero total count");

endmodule

[src/adaptive_range_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive range encoder
// Quantizes signed samples and codes them with an adaptive 64-bit range coder
// over a count tree model; emits the coded stream as 16-bit words.
// ----------------------------------------------------------------------------
// One sample at a time: an item is accepted, then goes through the tree walk,
// the bit-serial divider that forms range / total, the two split multiplies of
// the 64-bit range by a count and the low update, and the count update through
// the single tree memory port (skipped once the total count is full), then
// through renormalization, or the flush for a last sample, before the next
// sample can be taken. A renormalization step that must emit a word waits
// while the output is stalled. A last sample adds eight flush words, one per
// cycle while the output is not stalled. After reset, after each register
// write and after each flush the tree is rebuilt by a sweep during which no
// sample is taken.
module adaptive_range_encoder #(
  parameter int MAX_SYMBOL_BITS = are_pkg::MAX_SYMBOL_BITS_DEF,
  parameter int COUNT_BITS      = are_pkg::COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] sample,
  input  logic               is_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_word,
  output logic               final_word,
  output logic               count_overflow
);

  logic [4:0]          input_bits;
  logic [3:0]          symbol_bits;
  logic                cfg_wr;
  are_pkg::reg_idx_t   reg_sel;
  are_pkg::dp_op_t     op;
  are_pkg::dp_status_t status;

  assign pready  = 1'b1;
  assign reg_sel = are_pkg::reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      input_bits  <= are_pkg::INPUT_BITS_RST;
      symbol_bits <= are_pkg::SYMBOL_BITS_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        are_pkg::REG_INPUT_BITS:  input_bits  <= pwdata[4:0];
        are_pkg::REG_SYMBOL_BITS: symbol_bits <= pwdata[3:0];
        default:                  input_bits  <= input_bits;
      endcase
    end
  end

  // Register read.
  always_comb begin
    case (reg_sel)
      are_pkg::REG_INPUT_BITS:  prdata = {27'd0, input_bits};
      are_pkg::REG_SYMBOL_BITS: prdata = {28'd0, symbol_bits};
      default:                  prdata = '0;
    endcase
  end

  are_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr   (cfg_wr),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .op       (op)
  );

  are_dp #(
    .MAX_SYMBOL_BITS (MAX_SYMBOL_BITS),
    .COUNT_BITS      (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .status         (status),
    .input_bits     (input_bits),
    .symbol_bits    (symbol_bits),
    .sample         (sample),
    .is_last        (is_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word),
    .final_word     (final_word),
    .count_overflow (count_overflow)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive range encoder testbench
// Drives samples through the encoder under several register settings and
// idle patterns. A scoreboard predicts every coded word from its own model
// of the count tree and the range coder, and checks each word in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int TREE_SIZE = 2 << are_pkg::MAX_SYMBOL_BITS_DEF;
  localparam logic [63:0] COUNT_LIMIT = (64'd1 << are_pkg::COUNT_BITS_DEF) - 64'd1;
  localparam logic [63:0] RANGE_FLOOR = 64'h0000_FFFF_FFFF_FFFF;
  localparam int STALL_LIMIT = 5000;

  // One coded word as it leaves the block.
  typedef struct {
    logic [15:0] word;
    logic        fin;
    logic        ovf;
  } coded_word_t;

  // Model of the encoder and the queue of coded words it predicts.
  class coded_stream_sb;
    logic [4:0]  in_bits;
    logic [3:0]  sym_bits;
    logic [31:0] tree [TREE_SIZE];
    logic [63:0] total, range, low, pend;
    int          fill;
    bit          ovf_seen;
    coded_word_t words [$];
    int          errors;

    function new();
      in_bits  = are_pkg::INPUT_BITS_RST;
      sym_bits = are_pkg::SYMBOL_BITS_RST;
      errors   = 0;
      restart();
    endfunction

    function int qbits();
      int b;
      b = sym_bits;
      if (b == 0) b = 1;
      if (b > are_pkg::MAX_SYMBOL_BITS_DEF) b = are_pkg::MAX_SYMBOL_BITS_DEF;
      return b;
    endfunction

    function int base_of(int lvl, int qb);
      return (2 << qb) - (2 << (qb - lvl));
    endfunction

    // Rebuild the tree with one count per symbol and reset the coder.
    function void restart();
      int qb;
      int nsym;
      qb = qbits();
      nsym = 1 << qb;
      foreach (tree[i]) tree[i] = 0;
      for (int l = 0; l < qb; l++)
        for (int j = 0; j < (nsym >> l); j++)
          tree[(base_of(l, qb) + j) % TREE_SIZE] = 1 << l;
      total = nsym;
      range = '1;
      low = 0;
      pend = 0;
      fill = 0;
      ovf_seen = 0;
    endfunction

    function void configure(are_pkg::reg_idx_t idx, logic [31:0] val);
      if (idx == are_pkg::REG_INPUT_BITS) in_bits = val[4:0];
      else sym_bits = val[3:0];
      restart();
    endfunction

    // Dead-zone quantizer with clamping to the alphabet.
    function int quantize(logic signed [15:0] s, int qb);
      longint sv, m, q, sub, nsym;
      int del;
      sv = s;
      nsym = longint'(1) << qb;
      del = (in_bits > qb) ? in_bits - qb : 0;
      sub = (longint'(1) << del) >> 1;
      q = 0;
      if (sv > 0) begin
        m = sv - sub;
        if (m < 0) m = 0;
        q = m >>> del;
      end else if (sv < 0) begin
        m = -sv - sub;
        if (m < 0) m = 0;
        q = -(m >>> del);
      end
      q += nsym >> 1;
      if (q < 0) q = 0;
      if (q > nsym - 1) q = nsym - 1;
      return int'(q);
    endfunction

    function void emit(logic [63:0] w, bit fin);
      coded_word_t c;
      c.word = w[15:0];
      c.fin = fin;
      c.ovf = ovf_seen;
      words.push_back(c);
    endfunction

    // Code one accepted sample and queue the words it produces.
    function void note_sample(logic signed [15:0] s, logic last);
      int qb, sym;
      logic [63:0] cum, freq, prev;
      qb = qbits();
      sym = quantize(s, qb);
      cum = 0;
      for (int l = 0; l < qb; l++)
        if ((sym >> l) & 1) cum += tree[(base_of(l, qb) + (sym >> l) - 1) % TREE_SIZE];
      freq = tree[sym % TREE_SIZE];
      range = range / total;
      prev = low;
      low = low + range * cum;
      if (low < prev) pend = pend + 1;
      range = range * freq;
      if (total + 1 > COUNT_LIMIT) begin
        ovf_seen = 1;
      end else begin
        for (int l = 0; l < qb; l++)
          tree[(base_of(l, qb) + (sym >> l)) % TREE_SIZE]++;
        total++;
      end
      if (!last) begin
        while (range != 0 && range <= RANGE_FLOOR) begin
          if (fill >= 4) emit(pend >> 48, 0);
          else fill++;
          pend = (pend << 16) | (low >> 48);
          range = range << 16;
          low = low << 16;
        end
      end else begin
        for (int i = 0; i < 4; i++) emit(pend >> (48 - 16 * i), 0);
        for (int i = 0; i < 4; i++) emit(low >> (48 - 16 * i), i == 3);
        restart();
      end
    endfunction

    function void check_word(logic [15:0] w, logic fin, logic ovf);
      coded_word_t e;
      if (words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h fin %b ovf %b", w, fin, ovf);
        return;
      end
      e = words.pop_front();
      if (e.word !== w || e.fin !== fin || e.ovf !== ovf) begin
        errors++;
        if (errors <= 10)
          $display("word mismatch: expected %h/%b/%b, got %h/%b/%b",
                   e.word, e.fin, e.ovf, w, fin, ovf);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] sample = '0;
  logic is_last = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [15:0] out_word;
  logic final_word, count_overflow;

  int gap_pct = 0;
  int stall_pct = 0;
  int quiet = 0;
  coded_stream_sb sb = new();

  adaptive_range_encoder dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample), .is_last(is_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .final_word(final_word), .count_overflow(count_overflow)
  );

  always #5 clk = ~clk;

  // Random backpressure on the coded words.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Check every accepted word and watch for a hung block.
  always @(posedge clk) begin
    if (out_valid && !out_stall) sb.check_word(out_word, final_word, count_overflow);
    if ((out_valid && !out_stall) || (in_valid && !in_stall) || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Register write: setup cycle, then access cycle.
  task automatic write_reg(are_pkg::reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel = 1;
    pwrite = 1;
    penable = 0;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.configure(idx, val);
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
  endtask

  // Offer one sample word and hold it until the block takes it.
  task automatic send_sample(logic signed [15:0] s, logic last);
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    sample = s;
    is_last = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(s, last);
    @(negedge clk);
    in_valid = 0;
  endtask

  // Let all predicted words arrive, then give the block time to go idle.
  task automatic drain();
    while (sb.words.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_sample(int ib);
    int span;
    span = (ib > 15) ? 32767 : (1 << ib);
    if ($urandom_range(1)) return 16'($urandom);
    return 16'(int'($urandom_range(2 * span)) - span);
  endfunction

  int ib_list [8] = '{8, 16, 31, 3, 1, 16, 12, 0};
  int sb_list [8] = '{8, 8, 15, 0, 8, 1, 4, 3};

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Field extremes and clamping under the reset settings.
    send_sample(16'sh7FFF, 0);
    send_sample(-16'sd32768, 0);
    send_sample(0, 0);
    send_sample(1, 0);
    send_sample(-1, 0);
    send_sample(127, 0);
    send_sample(-128, 0);
    send_sample(200, 0);
    send_sample(-200, 1);
    send_sample(16'sh5555, 0);
    send_sample(16'shAAAA, 1);
    drain();

    // Dead zone at the edge of a step.
    write_reg(are_pkg::REG_INPUT_BITS, 12);
    foreach (ib_list[i]) begin
      if (i > 6) break;
    end
    send_sample(7, 0);
    send_sample(8, 0);
    send_sample(9, 0);
    send_sample(-8, 0);
    send_sample(-9, 0);
    send_sample(24, 1);
    drain();

    // Random messages over several settings and idle patterns.
    for (int p = 0; p < 8; p++) begin
      write_reg(are_pkg::REG_INPUT_BITS, ib_list[p]);
      write_reg(are_pkg::REG_SYMBOL_BITS, sb_list[p]);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 57; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 57; end
        default: begin gap_pct = 30; stall_pct = 30; end
      endcase
      for (int k = 0; k < 31; k++)
        send_sample(rand_sample(ib_list[p]), (k == 30) || ($urandom_range(9) == 0));
      drain();
    end

    if (sb.errors == 0 && sb.words.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

[files.f]
src/are_pkg.sv
src/are_ctrl.sv
src/are_dp.sv
src/adaptive_range_encoder.sv
tb/testbench.sv
